// File: design/assert_macros.svh
// assertion macros used by the frame decoder module
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// clocked assertion, ignored while reset is asserted
`define SFD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// clocked assertion that also holds during reset
`define SFD_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`else

`define SFD_ASSERT(lbl, prop, msg)
`define SFD_ASSERT_ALWAYS(lbl, prop, msg)

`endif

`endif

// File: design/sfd_pkg.sv
// constants and types of the sbus frame decoder
package sfd_pkg;

  localparam int ChanW      = 11;
  localparam int NumChan    = 16;
  localparam int StoredBytes = 24;
  localparam int ChanBytes  = 22;
  localparam int FlagsPos   = 23;
  localparam int ScaleShift = 20;

  typedef logic [ChanW-1:0] chan_t;

  localparam logic [7:0]  StartByte = 8'h0F;
  localparam logic [7:0]  EndByte   = 8'h00;
  localparam chan_t       RawOffset = 11'd172;
  localparam chan_t       OutMin    = 11'd1000;
  localparam chan_t       OutMax    = 11'd2000;
  localparam chan_t       QuotMax   = 11'd1000;
  // ceil(2^20 * 1000 / 1536), exact floor for raw offsets up to 1875
  localparam logic [19:0] ScaleMul  = 20'd682667;

endpackage

// File: design/sfd_chan_scale.sv
// scales one raw 11-bit channel to the 1000..2000 range
module sfd_chan_scale import sfd_pkg::*; (
  input  chan_t raw_i,
  output chan_t value_o
);

  chan_t       diff;
  logic [30:0] prod;
  chan_t       quot;

  assign diff = raw_i - RawOffset;
  assign prod = 31'(diff) * 31'(ScaleMul);
  assign quot = prod[ScaleShift +: ChanW];

  always_comb begin
    priority if (raw_i <= RawOffset) begin
      value_o = OutMin;
    end else if (quot > QuotMax) begin
      value_o = OutMax;
    end else begin
      value_o = quot + OutMin;
    end
  end

endmodule

// File: design/sbus_frame_decoder.sv
// sbus frame decoder top level: byte framing, frame snapshot and channel drain
//
//   port group   direction  beat                         handshake
//   rx byte      in         one serial byte              in_valid_i / in_stall_o
//   channel      out        index, value, flags, last    out_valid_o / out_stall_i
//
// a byte beat is taken every cycle while in_stall_o is low; a good frame's end byte starts
// 16 channel beats, leaving one per cycle while out_stall_i is low through the single shared
// scaler, each registered once drain_q is set; a frame costs 25 byte beats in and 16 out
// in_stall_o rises only while the end slot is awaited and the last frame still drains
// reset clears phase, byte count and the drain and valid flags; the byte store is not cleared
`include "assert_macros.svh"

module sbus_frame_decoder import sfd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  rx_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [3:0]  channel_index_o,
  output logic [10:0] channel_value_o,
  output logic [7:0]  frame_flags_o,
  output logic        last_channel_o
);

  localparam logic [1:0] PhWait = 2'd0;
  localparam logic [1:0] PhData = 2'd1;
  localparam logic [1:0] PhEnd  = 2'd2;

  localparam logic [4:0] StoredCnt = 5'(StoredBytes);
  localparam logic [3:0] LastChan  = 4'(NumChan - 1);

  logic [1:0] phase_q, phase_d;
  logic [4:0] count_q, count_d;
  logic       store_we;
  logic [4:0] store_idx;
  logic [7:0] store_q [StoredBytes];

  logic [8*ChanBytes-1:0] data_vec;
  logic [8*ChanBytes-1:0] snap_q;
  logic [7:0]             flags_q;
  chan_t                  raw_arr [NumChan];
  chan_t                  scaled;

  logic       in_accept;
  logic       decode;
  logic       load;
  logic       drain_q;
  logic [3:0] chan_q;

  logic       out_valid_q;
  logic [3:0] index_q;
  chan_t      value_q;
  logic [7:0] oflags_q;
  logic       last_q;

  assign in_stall_o = drain_q && (phase_q == PhEnd);
  assign in_accept  = in_valid_i && !in_stall_o;
  assign decode     = in_accept && (phase_q == PhEnd) && (rx_byte_i == EndByte);
  assign load       = drain_q && (!out_valid_q || !out_stall_i);

  // byte framing
  always_comb begin
    phase_d   = phase_q;
    count_d   = count_q;
    store_we  = 1'b0;
    store_idx = count_q;
    if (in_accept) begin
      unique case (phase_q)
        PhData: begin
          if (count_q < StoredCnt) begin
            store_we = 1'b1;
            count_d  = count_q + 5'd1;
          end
          if (count_d >= StoredCnt) begin
            phase_d = PhEnd;
          end
        end
        PhEnd: begin
          phase_d = PhWait;
          count_d = '0;
        end
        default: begin
          if (rx_byte_i == StartByte) begin
            store_we  = 1'b1;
            store_idx = '0;
            count_d   = 5'd1;
            phase_d   = PhData;
          end else begin
            count_d = '0;
            phase_d = PhWait;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhWait;
      count_q <= '0;
    end else begin
      phase_q <= phase_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (store_we) begin
      store_q[store_idx] <= rx_byte_i;
    end
  end

  // channel bytes packed little-endian, byte 1 at bit 0
  always_comb begin
    for (int k = 0; k < ChanBytes; k++) begin
      data_vec[8*k +: 8] = store_q[k+1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (decode) begin
      snap_q  <= data_vec;
      flags_q <= store_q[FlagsPos];
    end
  end

  always_comb begin
    for (int c = 0; c < NumChan; c++) begin
      raw_arr[c] = snap_q[ChanW*c +: ChanW];
    end
  end

  sfd_chan_scale u_scale (
    .raw_i   (raw_arr[chan_q]),
    .value_o (scaled)
  );

  // channel drain
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      drain_q     <= 1'b0;
      chan_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (decode) begin
        drain_q <= 1'b1;
        chan_q  <= '0;
      end else if (load) begin
        chan_q <= chan_q + 4'd1;
        if (chan_q == LastChan) begin
          drain_q <= 1'b0;
        end
      end
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      index_q  <= chan_q;
      value_q  <= scaled;
      oflags_q <= flags_q;
      last_q   <= (chan_q == LastChan);
    end
  end

  assign out_valid_o     = out_valid_q;
  assign channel_index_o = index_q;
  assign channel_value_o = value_q;
  assign frame_flags_o   = oflags_q;
  assign last_channel_o  = last_q;

  `SFD_ASSERT(a_decode_starts_drain, decode |=> (drain_q && (chan_q == 4'd0)), "drain did not start")
  `SFD_ASSERT(a_idle_chan_zero, !drain_q |-> (chan_q == 4'd0), "channel counter left nonzero")
  `SFD_ASSERT(a_end_full, (phase_q == PhEnd) |-> (count_q == StoredCnt), "end phase without full frame")
  `SFD_ASSERT_ALWAYS(a_count_range, count_q <= StoredCnt, "byte count beyond frame")
  `SFD_ASSERT(a_last_index, out_valid_o |-> (last_channel_o == (channel_index_o == LastChan)), "last flag mismatch")

endmodule

// File: dv/tb_top.sv
// testbench for the sbus frame decoder: byte stream in, predicted channel beats checked out
module tb_top;
  import sfd_pkg::*;

  localparam int ScaleNum   = 1000;
  localparam int ScaleDen   = 1536;
  localparam int ScaleBase  = 1000;
  localparam int FrameBytes = StoredBytes + 1;
  localparam int RandBytes  = 425;

  typedef enum logic [1:0] {PH_WAIT, PH_DATA, PH_END} phase_e;
  typedef enum logic [1:0] {ST_NONE, ST_RANDOM, ST_PERIODIC, ST_HEAVY} stall_mode_e;

  typedef struct packed {
    logic [3:0]  idx;
    logic [10:0] value;
    logic [7:0]  flags;
    logic        last;
  } chan_beat_t;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [7:0]  rx_byte_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [3:0]  channel_index_o;
  logic [10:0] channel_value_o;
  logic [7:0]  frame_flags_o;
  logic        last_channel_o;

  sbus_frame_decoder dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .rx_byte_i       (rx_byte_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .channel_index_o (channel_index_o),
    .channel_value_o (channel_value_o),
    .frame_flags_o   (frame_flags_o),
    .last_channel_o  (last_channel_o)
  );

  phase_e     trk_phase = PH_WAIT;
  int         trk_count = 0;
  logic [7:0] trk_store [StoredBytes];
  chan_beat_t chan_exp_q [$];
  chan_beat_t got_beat;
  chan_beat_t exp_beat;
  int         mismatch_cnt = 0;
  int         burst_left = 0;
  bit         gaps_on = 1'b1;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #3_000_000;
    $display("tb_top failed");
    $finish;
  end

  function automatic chan_t scale_raw(input chan_t raw);
    int v;
    v = (int'(raw) - int'(RawOffset)) * ScaleNum / ScaleDen + ScaleBase;
    if (v < int'(OutMin)) v = int'(OutMin);
    if (v > int'(OutMax)) v = int'(OutMax);
    return chan_t'(v);
  endfunction

  // follows the framing and queues the sixteen channel beats of a good frame
  function automatic void track_byte(input logic [7:0] b);
    logic [8*ChanBytes-1:0] payload;
    chan_beat_t beat;
    case (trk_phase)
      PH_DATA: begin
        if (trk_count < StoredBytes) begin
          trk_store[trk_count] = b;
          trk_count++;
        end
        if (trk_count >= StoredBytes) trk_phase = PH_END;
      end
      PH_END: begin
        trk_phase = PH_WAIT;
        trk_count = 0;
        if (b == EndByte) begin
          for (int i = 0; i < ChanBytes; i++) payload[8*i +: 8] = trk_store[i+1];
          for (int ch = 0; ch < NumChan; ch++) begin
            beat.idx   = 4'(ch);
            beat.value = scale_raw(payload[ch*ChanW +: ChanW]);
            beat.flags = trk_store[FlagsPos];
            beat.last  = (ch == NumChan - 1);
            chan_exp_q.push_back(beat);
          end
        end
      end
      default: begin
        trk_phase = PH_WAIT;
        trk_count = 0;
        if (b == StartByte) begin
          trk_store[0] = b;
          trk_count = 1;
          trk_phase = PH_DATA;
        end
      end
    endcase
  endfunction

  function automatic void note_mismatch(input string what, input chan_beat_t e,
                                        input chan_beat_t g);
    mismatch_cnt++;
    if (mismatch_cnt <= 10)
      $display("%0t %s: exp idx %0d value %0d flags %02h last %0b, got idx %0d value %0d flags %02h last %0b",
               $realtime, what, e.idx, e.value, e.flags, e.last,
               g.idx, g.value, g.flags, g.last);
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got_beat = {channel_index_o, channel_value_o, frame_flags_o, last_channel_o};
      if (chan_exp_q.size() == 0) begin
        note_mismatch("unexpected channel beat", '0, got_beat);
      end else begin
        exp_beat = chan_exp_q.pop_front();
        if (got_beat !== exp_beat) note_mismatch("channel beat mismatch", exp_beat, got_beat);
      end
    end
  end

  // receiver stall pattern, switching between modes
  initial begin
    stall_mode_e mode;
    int left;
    int period;
    int duty;
    int cyc;
    out_stall_i <= 1'b0;
    mode = ST_NONE;
    left = 0;
    period = 2;
    duty = 1;
    cyc = 0;
    forever begin
      @(posedge clk_i);
      if (left == 0) begin
        mode   = stall_mode_e'($urandom_range(0, 3));
        left   = $urandom_range(64, 256);
        period = $urandom_range(2, 8);
        duty   = $urandom_range(1, period - 1);
      end
      left--;
      cyc++;
      case (mode)
        ST_NONE:     out_stall_i <= 1'b0;
        ST_RANDOM:   out_stall_i <= ($urandom_range(0, 2) == 0);
        ST_PERIODIC: out_stall_i <= ((cyc % period) < duty);
        default:     out_stall_i <= ($urandom_range(0, 7) != 0);
      endcase
    end
  end

  task automatic send_byte(input logic [7:0] b);
    int gap;
    if (gaps_on && burst_left <= 0) begin
      gap = $urandom_range(1, 12);
      in_valid_i <= 1'b0;
      rx_byte_i  <= 8'($urandom);
      repeat (gap) @(posedge clk_i);
      burst_left = $urandom_range(1, 40);
    end
    in_valid_i <= 1'b1;
    rx_byte_i  <= b;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    track_byte(b);
    burst_left--;
  endtask

  task automatic send_frame(input logic [8*ChanBytes-1:0] payload, input logic [7:0] flags,
                            input logic [7:0] tail);
    send_byte(StartByte);
    for (int i = 0; i < ChanBytes; i++) send_byte(payload[8*i +: 8]);
    send_byte(flags);
    send_byte(tail);
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    burst_left = 0;
    while (chan_exp_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  function automatic chan_t rand_raw();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return 11'h7FF;
      2:       return chan_t'($urandom_range(160, 185));
      3:       return chan_t'($urandom_range(1700, 1720));
      default: return chan_t'($urandom);
    endcase
  endfunction

  function automatic logic [8*ChanBytes-1:0] rand_payload();
    logic [8*ChanBytes-1:0] p;
    if ($urandom_range(0, 3) == 0) begin
      for (int i = 0; i < ChanBytes; i++) p[8*i +: 8] = 8'($urandom);
    end else begin
      for (int ch = 0; ch < NumChan; ch++) p[ch*ChanW +: ChanW] = rand_raw();
    end
    return p;
  endfunction

  // non-start bytes while waiting are ignored
  task automatic test_idle_bytes();
    send_byte(EndByte);
    send_byte(8'hFF);
    send_byte(8'hF0);
    send_byte(8'h0E);
    send_byte(8'h10);
  endtask

  // both clamp limits and the values right around them
  task automatic test_clamp_edges();
    send_frame({11'd1, 11'd2046, 11'h2AA, 11'h555, 11'd1024, 11'd1711, 11'd1710, 11'd1709,
                11'd1708, 11'd1707, 11'd174, 11'd173, 11'd172, 11'd171, 11'h7FF, 11'd0},
               8'hFF, EndByte);
  endtask

  // a start byte in the end slot drops the frame
  task automatic test_bad_tail();
    wait_drained();
    send_frame(rand_payload(), 8'h00, StartByte);
  endtask

  task automatic test_random_frames();
    int sent;
    int frames;
    logic [7:0] b;
    logic [7:0] tail;
    sent = 0;
    frames = 0;
    while (sent < RandBytes) begin
      gaps_on = ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 2) == 0) begin
        repeat ($urandom_range(1, 3)) begin
          do b = 8'($urandom); while (b == StartByte);
          send_byte(b);
        end
      end
      if ($urandom_range(0, 9) == 0) tail = 8'($urandom_range(1, 255));
      else tail = EndByte;
      send_frame(rand_payload(), 8'($urandom), tail);
      sent += FrameBytes;
      frames++;
      if (frames % 6 == 0) wait_drained();
    end
    gaps_on = 1'b1;
  endtask

  initial begin
    rst_ni     <= 1'b0;
    in_valid_i <= 1'b0;
    rx_byte_i  <= '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_idle_bytes();
    test_clamp_edges();
    test_bad_tail();
    test_random_frames();
    wait_drained();
    repeat (32) @(posedge clk_i);
    if (chan_exp_q.size() != 0) begin
      $display("%0d channel beats never arrived", chan_exp_q.size());
      mismatch_cnt += chan_exp_q.size();
    end
    if (mismatch_cnt == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule
